### rtl/assert_macros.svh
// assertion macros used by the converter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must be followed by another in the next cycle
`define CTC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### rtl/ctc_pkg.sv
// types and constants of the coo to csr converter
package ctc_pkg;

  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_ADD      = 3'd1;
  localparam logic [2:0] OP_BUILD    = 3'd2;
  localparam logic [2:0] OP_READ_PTR = 3'd3;
  localparam logic [2:0] OP_READ_EDGE = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_PHASE  = 2'd3;

  localparam logic [1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [1:0] CFG_SYMMETRIC = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [10:0] entry_row;
    logic [10:0] entry_col;
    logic [63:0] entry_value;
    logic [11:0] read_index;
  } ctc_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] row_pointer;
    logic [9:0]  neighbour;
    logic [63:0] edge_value;
    logic [12:0] edge_total;
    logic [11:0] stored_entries;
  } ctc_res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_RESP,
    S_RDOFF,
    S_RDEDGE,
    S_CNT_E,
    S_CNT_R,
    S_CNT_RW,
    S_CNT_C,
    S_CNT_CW,
    S_CHK,
    S_PFX_R,
    S_PFX_W,
    S_SC_E,
    S_SC_R,
    S_SC_RW,
    S_SC_C,
    S_SC_CW
  } ctc_state_e;

endpackage

### rtl/coo_to_csr_converter_top.sv
// top level of the coo to csr converter: sequencer, memories and shared adder
//
// channel   direction  handshake                 payload
// command   in         start & !busy             cmd_i (ctc_cmd_t)
// result    out        done_o, one cycle         res_o (ctc_res_t)
// config    in         cfg_valid_i & cfg_ready_o cfg_index_i, cfg_data_i
//
// add, unknown opcodes and failed reads respond directly; reads pass a read state
// clear sweeps the row offset memory, all MAX_VERTICES+1 entries, one entry a cycle
// build counts degrees per entry (twice if mirrored), then forms the prefix sum
// over the offset memory, then scatters entries; on failure a sweep runs instead
// after reset the same sweep of all MAX_VERTICES+1 offset entries runs with busy high
// results cannot be stalled; done_o is high for one cycle
module coo_to_csr_converter_top #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_ENTRIES  = 2048,
  parameter int MAX_EDGES    = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ctc_pkg::ctc_cmd_t cmd_i,
  output logic              done_o,
  output ctc_pkg::ctc_res_t res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [10:0]       cfg_data_i
);

  localparam int RW  = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int OAW = $clog2(MAX_VERTICES + 1);
  localparam int EAW = $clog2(MAX_ENTRIES);
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int GAW = $clog2(MAX_EDGES);
  localparam int CW0 = $clog2(2 * MAX_ENTRIES + 1);
  localparam int CW1 = $clog2(MAX_EDGES + 2);
  localparam int CW  = (CW0 > CW1) ? CW0 : CW1;
  localparam int EW  = 2 * RW + 64;
  localparam int GW  = RW + 64;

  ctc_pkg::ctc_state_e state_q, state_d;
  logic [OAW-1:0] idx_q, idx_d;
  logic [ECW-1:0] ent_q, ent_d;
  logic [CW-1:0]  acc_q, acc_d;
  logic [CW-1:0]  tot_q, tot_d;
  logic [ECW-1:0] entry_counter_q, entry_counter_d;
  logic [CW-1:0]  total_edges_q, total_edges_d;
  logic           built_q, built_d;
  logic           rep_q, rep_d;
  ctc_pkg::ctc_res_t res_q, res_d;
  logic [10:0]    row_count_q, col_count_q;
  logic           sym_q;

  logic           ent_we;
  logic [EW-1:0]  ent_wdata, ent_rd;
  logic           off_we;
  logic [OAW-1:0] off_waddr, off_raddr;
  logic [CW-1:0]  off_wdata, off_rd;
  logic           edge_we;
  logic [GAW-1:0] edge_waddr, edge_raddr;
  logic [GW-1:0]  edge_wdata, edge_rd;
  logic [CW-1:0]  alu_a, alu_b, alu_y;
  logic           alu_sub;

  logic [VCW-1:0] rc_cl, cc_cl, vcnt;
  logic [RW-1:0]  add_r, add_c, e_row, e_col;
  logic [63:0]    e_val;
  logic           add_bad, add_mirr, add_full, e_mirr;
  logic [1:0]     add_need;
  logic           accept;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= 11'd1024;
      col_count_q <= 11'd1024;
      sym_q       <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ctc_pkg::CFG_ROW_COUNT: row_count_q <= cfg_data_i;
        ctc_pkg::CFG_COL_COUNT: col_count_q <= cfg_data_i;
        ctc_pkg::CFG_SYMMETRIC: sym_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign rc_cl = (32'(row_count_q) > 32'(MAX_VERTICES)) ? VCW'(MAX_VERTICES)
                                                      : VCW'(row_count_q);
  assign cc_cl = (32'(col_count_q) > 32'(MAX_VERTICES)) ? VCW'(MAX_VERTICES)
                                                      : VCW'(col_count_q);
  assign vcnt  = (rc_cl > cc_cl) ? rc_cl : cc_cl;

  assign add_r    = RW'(cmd_i.entry_row - 11'd1);
  assign add_c    = RW'(cmd_i.entry_col - 11'd1);
  assign add_bad  = (cmd_i.entry_row == 11'd0) || (32'(cmd_i.entry_row) > 32'(rc_cl)) ||
                    (cmd_i.entry_col == 11'd0) || (32'(cmd_i.entry_col) > 32'(cc_cl));
  assign add_mirr = sym_q && (add_r != add_c);
  assign add_need = add_mirr ? 2'd2 : 2'd1;
  assign add_full = (32'(entry_counter_q) >= 32'(MAX_ENTRIES)) ||
                    (32'(total_edges_q) + 32'(add_need) > 32'(MAX_EDGES));

  assign e_row  = ent_rd[EW-1 -: RW];
  assign e_col  = ent_rd[RW+63 -: RW];
  assign e_val  = ent_rd[63:0];
  assign e_mirr = sym_q && (e_row != e_col);

  assign ent_wdata = {add_r, add_c, cmd_i.entry_value};

  ctc_ram #(.DW(EW), .DEPTH(MAX_ENTRIES), .AW(EAW)) u_entries (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (entry_counter_q[EAW-1:0]),
    .wdata_i (ent_wdata),
    .raddr_i (ent_q[EAW-1:0]),
    .rdata_o (ent_rd)
  );

  ctc_ram #(.DW(CW), .DEPTH(MAX_VERTICES + 1), .AW(OAW)) u_offsets (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (off_waddr),
    .wdata_i (off_wdata),
    .raddr_i (off_raddr),
    .rdata_o (off_rd)
  );

  ctc_ram #(.DW(GW), .DEPTH(MAX_EDGES), .AW(GAW)) u_edges (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rd)
  );

  ctc_alu #(.W(CW)) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .y_o   (alu_y)
  );

  assign edge_raddr = GAW'(cmd_i.read_index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ctc_pkg::S_CLR;
      idx_q           <= '0;
      ent_q           <= '0;
      acc_q           <= '0;
      tot_q           <= '0;
      entry_counter_q <= '0;
      total_edges_q   <= '0;
      built_q         <= 1'b0;
      rep_q           <= 1'b0;
    end else begin
      state_q         <= state_d;
      idx_q           <= idx_d;
      ent_q           <= ent_d;
      acc_q           <= acc_d;
      tot_q           <= tot_d;
      entry_counter_q <= entry_counter_d;
      total_edges_q   <= total_edges_d;
      built_q         <= built_d;
      rep_q           <= rep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    ent_d           = ent_q;
    acc_d           = acc_q;
    tot_d           = tot_q;
    entry_counter_d = entry_counter_q;
    total_edges_d   = total_edges_q;
    built_d         = built_q;
    rep_d           = rep_q;
    res_d           = res_q;
    ent_we          = 1'b0;
    off_we          = 1'b0;
    off_waddr       = idx_q;
    off_wdata       = '0;
    off_raddr       = idx_q;
    edge_we         = 1'b0;
    edge_waddr      = GAW'(alu_y);
    edge_wdata      = {e_col, e_val};
    alu_a           = off_rd;
    alu_b           = CW'(1);
    alu_sub         = 1'b0;

    unique case (state_q)
      ctc_pkg::S_IDLE: begin
        off_raddr = OAW'(cmd_i.read_index);
        if (accept) begin
          res_d   = '0;
          state_d = ctc_pkg::S_RESP;
          unique case (cmd_i.opcode)
            ctc_pkg::OP_CLEAR: begin
              entry_counter_d = '0;
              total_edges_d   = '0;
              built_d         = 1'b0;
              idx_d           = '0;
              rep_d           = 1'b1;
              state_d         = ctc_pkg::S_CLR;
            end
            ctc_pkg::OP_ADD: begin
              if (built_q) begin
                res_d.status = ctc_pkg::ST_PHASE;
              end else if (add_bad) begin
                res_d.status = ctc_pkg::ST_RANGE;
              end else if (add_full) begin
                res_d.status = ctc_pkg::ST_FULL;
              end else begin
                ent_we          = 1'b1;
                entry_counter_d = entry_counter_q + ECW'(1);
                total_edges_d   = total_edges_q + CW'(add_need);
              end
            end
            ctc_pkg::OP_BUILD: begin
              if (built_q) begin
                res_d.status = ctc_pkg::ST_PHASE;
              end else begin
                ent_d   = '0;
                tot_d   = '0;
                state_d = ctc_pkg::S_CNT_E;
              end
            end
            ctc_pkg::OP_READ_PTR: begin
              if (!built_q) begin
                res_d.status = ctc_pkg::ST_PHASE;
              end else if (32'(cmd_i.read_index) > 32'(vcnt)) begin
                res_d.status = ctc_pkg::ST_RANGE;
              end else begin
                state_d = ctc_pkg::S_RDOFF;
              end
            end
            ctc_pkg::OP_READ_EDGE: begin
              if (!built_q) begin
                res_d.status = ctc_pkg::ST_PHASE;
              end else if ((32'(cmd_i.read_index) >= 32'(total_edges_q)) ||
                           (32'(cmd_i.read_index) >= 32'(MAX_EDGES))) begin
                res_d.status = ctc_pkg::ST_RANGE;
              end else begin
                state_d = ctc_pkg::S_RDEDGE;
              end
            end
            default: res_d.status = ctc_pkg::ST_PHASE;
          endcase
        end
      end
      ctc_pkg::S_CLR: begin
        off_we = 1'b1;
        if (idx_q == OAW'(MAX_VERTICES)) begin
          state_d = rep_q ? ctc_pkg::S_RESP : ctc_pkg::S_IDLE;
        end else begin
          idx_d = idx_q + OAW'(1);
        end
      end
      ctc_pkg::S_RESP: begin
        state_d = ctc_pkg::S_IDLE;
      end
      ctc_pkg::S_RDOFF: begin
        res_d.row_pointer = 13'(off_rd);
        state_d           = ctc_pkg::S_RESP;
      end
      ctc_pkg::S_RDEDGE: begin
        res_d.neighbour  = 10'(edge_rd[GW-1 -: RW]);
        res_d.edge_value = edge_rd[63:0];
        state_d          = ctc_pkg::S_RESP;
      end
      ctc_pkg::S_CNT_E: begin
        state_d = (ent_q == entry_counter_q) ? ctc_pkg::S_CHK : ctc_pkg::S_CNT_R;
      end
      ctc_pkg::S_CNT_R: begin
        off_raddr = OAW'(e_row);
        state_d   = ctc_pkg::S_CNT_RW;
      end
      ctc_pkg::S_CNT_RW: begin
        off_we    = 1'b1;
        off_waddr = OAW'(e_row);
        off_wdata = alu_y;
        tot_d     = tot_q + CW'(1);
        if (e_mirr) begin
          state_d = ctc_pkg::S_CNT_C;
        end else begin
          ent_d   = ent_q + ECW'(1);
          state_d = ctc_pkg::S_CNT_E;
        end
      end
      ctc_pkg::S_CNT_C: begin
        off_raddr = OAW'(e_col);
        state_d   = ctc_pkg::S_CNT_CW;
      end
      ctc_pkg::S_CNT_CW: begin
        off_we    = 1'b1;
        off_waddr = OAW'(e_col);
        off_wdata = alu_y;
        tot_d     = tot_q + CW'(1);
        ent_d     = ent_q + ECW'(1);
        state_d   = ctc_pkg::S_CNT_E;
      end
      ctc_pkg::S_CHK: begin
        idx_d = '0;
        acc_d = '0;
        if (32'(tot_q) > 32'(MAX_EDGES)) begin
          res_d.status = ctc_pkg::ST_FULL;
          rep_d        = 1'b1;
          state_d      = ctc_pkg::S_CLR;
        end else begin
          state_d = ctc_pkg::S_PFX_R;
        end
      end
      ctc_pkg::S_PFX_R: begin
        state_d = ctc_pkg::S_PFX_W;
      end
      ctc_pkg::S_PFX_W: begin
        alu_a     = acc_q;
        alu_b     = off_rd;
        off_we    = 1'b1;
        off_wdata = alu_y;
        acc_d     = alu_y;
        if (idx_q == OAW'(MAX_VERTICES)) begin
          ent_d   = '0;
          state_d = ctc_pkg::S_SC_E;
        end else begin
          idx_d   = idx_q + OAW'(1);
          state_d = ctc_pkg::S_PFX_R;
        end
      end
      ctc_pkg::S_SC_E: begin
        if (ent_q == entry_counter_q) begin
          total_edges_d = tot_q;
          built_d       = 1'b1;
          state_d       = ctc_pkg::S_RESP;
        end else begin
          state_d = ctc_pkg::S_SC_R;
        end
      end
      ctc_pkg::S_SC_R: begin
        off_raddr = OAW'(e_row);
        state_d   = ctc_pkg::S_SC_RW;
      end
      ctc_pkg::S_SC_RW: begin
        alu_sub   = 1'b1;
        off_we    = 1'b1;
        off_waddr = OAW'(e_row);
        off_wdata = alu_y;
        edge_we   = 1'b1;
        if (e_mirr) begin
          state_d = ctc_pkg::S_SC_C;
        end else begin
          ent_d   = ent_q + ECW'(1);
          state_d = ctc_pkg::S_SC_E;
        end
      end
      ctc_pkg::S_SC_C: begin
        off_raddr = OAW'(e_col);
        state_d   = ctc_pkg::S_SC_CW;
      end
      ctc_pkg::S_SC_CW: begin
        alu_sub    = 1'b1;
        off_we     = 1'b1;
        off_waddr  = OAW'(e_col);
        off_wdata  = alu_y;
        edge_we    = 1'b1;
        edge_wdata = {e_row, e_val};
        ent_d      = ent_q + ECW'(1);
        state_d    = ctc_pkg::S_SC_E;
      end
      default: state_d = ctc_pkg::S_IDLE;
    endcase
  end

  assign busy   = (state_q != ctc_pkg::S_IDLE);
  assign done_o = (state_q == ctc_pkg::S_RESP);

  always_comb begin
    res_o                = res_q;
    res_o.edge_total     = 13'(total_edges_q);
    res_o.stored_entries = 12'(entry_counter_q);
  end

`include "assert_macros.svh"

  `CTC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `CTC_ASSERT_NEXT(a_resp_idle, done_o, !busy && !done_o, "response not followed by idle")
  `CTC_ASSERT(a_total_bound, 32'(total_edges_q) <= 32'(MAX_EDGES), "edge total above limit")
  `CTC_ASSERT(a_count_bound, 32'(entry_counter_q) <= 32'(MAX_ENTRIES), "entry count above limit")

endmodule

### rtl/ctc_ram.sv
// single write port ram with registered read
module ctc_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/ctc_alu.sv
// shared adder for degree counts, prefix sum and pointer decrement
module ctc_alu #(
  parameter int W = 13
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] y_o
);

  always_comb begin
    if (sub_i) begin
      y_o = a_i - b_i;
    end else begin
      y_o = a_i + b_i;
    end
  end

endmodule

### verif/ctc_checker.sv
// checker of the coo to csr converter: predicts each result and compares it with the block
module ctc_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  ctc_pkg::ctc_cmd_t cmd_i,
  input  logic              done_i,
  input  ctc_pkg::ctc_res_t res_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [10:0]       cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int NV = 1024;
  localparam int NE = 2048;
  localparam int NX = 4096;

  logic [10:0] rows_reg, cols_reg;
  logic        sym_reg;

  logic [9:0]  ent_row [NE];
  logic [9:0]  ent_col [NE];
  logic [63:0] ent_val [NE];
  int          offsets [NV+1];
  logic [9:0]  adj_col [NX];
  logic [63:0] adj_val [NX];
  int          n_entries, n_edges;
  bit          is_built;

  ctc_pkg::ctc_res_t expected_results[$];

  function automatic int clamp_dim(input logic [10:0] v);
    return (v > NV) ? NV : int'(v);
  endfunction

  function automatic bit mirrored(input int r, input int c);
    return sym_reg && (r != c);
  endfunction

  task automatic reset_tables();
    for (int i = 0; i <= NV; i++) offsets[i] = 0;
    n_entries = 0;
    n_edges = 0;
    is_built = 0;
  endtask

  task automatic build_csr(output logic [1:0] st);
    int tot;
    int p;
    tot = 0;
    for (int i = 0; i <= NV; i++) offsets[i] = 0;
    for (int i = 0; i < n_entries; i++) begin
      offsets[ent_row[i]]++;
      tot++;
      if (mirrored(ent_row[i], ent_col[i])) begin
        offsets[ent_col[i]]++;
        tot++;
      end
    end
    if (tot > NX) begin
      for (int i = 0; i <= NV; i++) offsets[i] = 0;
      st = ctc_pkg::ST_FULL;
      return;
    end
    for (int i = 1; i <= NV; i++) offsets[i] += offsets[i-1];
    for (int i = 0; i < n_entries; i++) begin
      offsets[ent_row[i]]--;
      p = offsets[ent_row[i]];
      adj_col[p] = ent_col[i];
      adj_val[p] = ent_val[i];
      if (mirrored(ent_row[i], ent_col[i])) begin
        offsets[ent_col[i]]--;
        p = offsets[ent_col[i]];
        adj_col[p] = ent_row[i];
        adj_val[p] = ent_val[i];
      end
    end
    n_edges = tot;
    is_built = 1;
    st = ctc_pkg::ST_OK;
  endtask

  task automatic predict_csr_result(input ctc_pkg::ctc_cmd_t c, output ctc_pkg::ctc_res_t r);
    int need;
    int vc;
    r = '0;
    r.status = ctc_pkg::ST_OK;
    vc = (clamp_dim(rows_reg) > clamp_dim(cols_reg)) ? clamp_dim(rows_reg) : clamp_dim(cols_reg);
    case (c.opcode)
      ctc_pkg::OP_CLEAR: reset_tables();
      ctc_pkg::OP_ADD: begin
        if (is_built) r.status = ctc_pkg::ST_PHASE;
        else if (c.entry_row == 0 || c.entry_row > clamp_dim(rows_reg) ||
                 c.entry_col == 0 || c.entry_col > clamp_dim(cols_reg))
          r.status = ctc_pkg::ST_RANGE;
        else begin
          need = mirrored(int'(c.entry_row) - 1, int'(c.entry_col) - 1) ? 2 : 1;
          if (n_entries >= NE || n_edges + need > NX) r.status = ctc_pkg::ST_FULL;
          else begin
            ent_row[n_entries] = 10'(c.entry_row - 11'd1);
            ent_col[n_entries] = 10'(c.entry_col - 11'd1);
            ent_val[n_entries] = c.entry_value;
            n_entries++;
            n_edges += need;
          end
        end
      end
      ctc_pkg::OP_BUILD: begin
        if (is_built) r.status = ctc_pkg::ST_PHASE;
        else build_csr(r.status);
      end
      ctc_pkg::OP_READ_PTR: begin
        if (!is_built) r.status = ctc_pkg::ST_PHASE;
        else if (c.read_index > vc) r.status = ctc_pkg::ST_RANGE;
        else r.row_pointer = 13'(offsets[c.read_index]);
      end
      ctc_pkg::OP_READ_EDGE: begin
        if (!is_built) r.status = ctc_pkg::ST_PHASE;
        else if (c.read_index >= n_edges) r.status = ctc_pkg::ST_RANGE;
        else begin
          r.neighbour = adj_col[c.read_index];
          r.edge_value = adj_val[c.read_index];
        end
      end
      default: r.status = ctc_pkg::ST_PHASE;
    endcase
    r.edge_total = 13'(n_edges);
    r.stored_entries = 12'(n_entries);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    ctc_pkg::ctc_res_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      rows_reg = 11'd1024;
      cols_reg = 11'd1024;
      sym_reg = 1'b0;
      reset_tables();
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ctc_pkg::CFG_ROW_COUNT: rows_reg = cfg_data_i;
          ctc_pkg::CFG_COL_COUNT: cols_reg = cfg_data_i;
          ctc_pkg::CFG_SYMMETRIC: sym_reg = cfg_data_i[0];
          default: ;
        endcase
      end
      if (done_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(res_i.status), '0);
        end else begin
          want = expected_results.pop_front();
          if (res_i.status != want.status)
            report_mismatch("status", 64'(res_i.status), 64'(want.status));
          if (res_i.row_pointer != want.row_pointer)
            report_mismatch("row_pointer", 64'(res_i.row_pointer), 64'(want.row_pointer));
          if (res_i.neighbour != want.neighbour)
            report_mismatch("neighbour", 64'(res_i.neighbour), 64'(want.neighbour));
          if (res_i.edge_value != want.edge_value)
            report_mismatch("edge_value", res_i.edge_value, want.edge_value);
          if (res_i.edge_total != want.edge_total)
            report_mismatch("edge_total", 64'(res_i.edge_total), 64'(want.edge_total));
          if (res_i.stored_entries != want.stored_entries)
            report_mismatch("stored_entries", 64'(res_i.stored_entries),
                            64'(want.stored_entries));
        end
      end
      if (start_i && !busy_i) begin
        predict_csr_result(cmd_i, want);
        expected_results.push_back(want);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

### verif/tb_coo_to_csr_converter_top.sv
// testbench top of the coo to csr converter: stimulus, watchdog and verdict
module tb_coo_to_csr_converter_top;

  localparam int WATCHDOG_LIMIT = 200000;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  ctc_pkg::ctc_cmd_t cmd;
  logic              done_o;
  ctc_pkg::ctc_res_t res_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [10:0]       cfg_data_i;

  int fail_count, pending;
  int items_sent;
  int idle_cycles = 0;
  int burst_left;
  int cur_rows, cur_cols;

  coo_to_csr_converter_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd),
    .done_o(done_o), .res_o(res_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  ctc_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .cmd_i(cmd),
    .done_i(done_o), .res_i(res_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_cmd(input logic [2:0] op, input int r, input int c,
                          input logic [63:0] v, input int idx);
    int gap;
    if (burst_left == 0) begin
      start = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    cmd.opcode = op;
    cmd.entry_row = 11'(r);
    cmd.entry_col = 11'(c);
    cmd.entry_value = v;
    cmd.read_index = 12'(idx);
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_idle();
    start = 1'b0;
    @(negedge clk_i);
    while (pending != 0 || busy) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input int val);
    cfg_index_i = idx;
    cfg_data_i = 11'(val);
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == ctc_pkg::CFG_ROW_COUNT) cur_rows = (val > 1024) ? 1024 : val;
    if (idx == ctc_pkg::CFG_COL_COUNT) cur_cols = (val > 1024) ? 1024 : val;
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return 1024;
      2: return $urandom_range(1025, 2047);
      3: return $urandom_range(1, 1024);
      default: return $urandom_range(2, 20);
    endcase
  endfunction

  task automatic add_random(input int bad_pct);
    int r, c;
    r = $urandom_range(1, cur_rows);
    c = $urandom_range(1, cur_cols);
    if ($urandom_range(0, 99) < bad_pct) begin
      case ($urandom_range(0, 3))
        0: r = 0;
        1: c = 0;
        2: r = $urandom_range(cur_rows + 1, 2047);
        default: c = $urandom_range(cur_cols + 1, 2047);
      endcase
    end
    send_cmd(ctc_pkg::OP_ADD, r, c, rand_value(), $urandom_range(0, 4095));
  endtask

  task automatic read_random(input int verts, input int edges);
    int idx;
    if ($urandom_range(0, 1) == 0) begin
      idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, verts + 1);
      send_cmd(ctc_pkg::OP_READ_PTR, $urandom_range(0, 2047), $urandom_range(0, 2047),
               rand_value(), idx);
    end else begin
      idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, edges + 2);
      send_cmd(ctc_pkg::OP_READ_EDGE, $urandom_range(0, 2047), $urandom_range(0, 2047),
               rand_value(), idx);
    end
  endtask

  initial begin
    int n_add, n_read, verts;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = ctc_pkg::CFG_ROW_COUNT;
    cfg_data_i = '0;
    items_sent = 0;
    burst_left = 0;
    cur_rows = 1024;
    cur_cols = 1024;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: phases, extremes and error codes
    send_cmd(ctc_pkg::OP_READ_PTR, 0, 0, '0, 0);
    send_cmd(ctc_pkg::OP_READ_EDGE, 0, 0, '0, 0);
    send_cmd(ctc_pkg::OP_ADD, 1, 1, '0, 0);
    send_cmd(ctc_pkg::OP_ADD, 1024, 1024, '1, 4095);
    send_cmd(ctc_pkg::OP_ADD, 1, 1024, 64'h8000_0000_0000_0001, 0);
    send_cmd(ctc_pkg::OP_ADD, 0, 5, '1, 0);
    send_cmd(ctc_pkg::OP_ADD, 5, 0, '1, 0);
    send_cmd(ctc_pkg::OP_ADD, 1025, 5, '1, 0);
    send_cmd(ctc_pkg::OP_ADD, 5, 2047, '1, 0);
    send_cmd(3'd5, 2047, 2047, '1, 4095);
    send_cmd(3'd6, 0, 0, '0, 0);
    send_cmd(3'd7, 0, 0, '0, 0);
    send_cmd(ctc_pkg::OP_BUILD, 0, 0, '0, 0);
    send_cmd(ctc_pkg::OP_BUILD, 0, 0, '0, 0);
    send_cmd(ctc_pkg::OP_ADD, 2, 2, '0, 0);
    send_cmd(ctc_pkg::OP_READ_PTR, 0, 0, '0, 0);
    send_cmd(ctc_pkg::OP_READ_PTR, 0, 0, '0, 1024);
    send_cmd(ctc_pkg::OP_READ_PTR, 0, 0, '0, 1025);
    send_cmd(ctc_pkg::OP_READ_EDGE, 0, 0, '0, 2);
    send_cmd(ctc_pkg::OP_READ_EDGE, 0, 0, '0, 3);
    send_cmd(ctc_pkg::OP_READ_EDGE, 0, 0, '0, 4095);
    send_cmd(ctc_pkg::OP_CLEAR, 0, 0, '0, 0);
    send_cmd(ctc_pkg::OP_READ_PTR, 0, 0, '0, 0);

    // small symmetric matrix with many repeated entries
    wait_idle();
    write_cfg(ctc_pkg::CFG_ROW_COUNT, 3);
    write_cfg(ctc_pkg::CFG_COL_COUNT, 3);
    write_cfg(ctc_pkg::CFG_SYMMETRIC, 1);
    send_cmd(ctc_pkg::OP_CLEAR, 0, 0, '0, 0);
    for (int i = 0; i < 200; i++) add_random(0);
    for (int i = 0; i < 8; i++) send_cmd(ctc_pkg::OP_ADD, 2, 2, rand_value(), 0);
    send_cmd(ctc_pkg::OP_BUILD, 0, 0, '0, 0);
    send_cmd(ctc_pkg::OP_READ_EDGE, 0, 0, '0, 4095);
    send_cmd(ctc_pkg::OP_READ_PTR, 0, 0, '0, 3);
    for (int i = 0; i < 10; i++) read_random(3, 420);

    // random phases
    while (items_sent < 1450) begin
      wait_idle();
      if ($urandom_range(0, 1)) write_cfg(ctc_pkg::CFG_ROW_COUNT, pick_dim());
      if ($urandom_range(0, 1)) write_cfg(ctc_pkg::CFG_COL_COUNT, pick_dim());
      if ($urandom_range(0, 1)) write_cfg(ctc_pkg::CFG_SYMMETRIC, $urandom_range(0, 2047));
      send_cmd(ctc_pkg::OP_CLEAR, 0, 0, '0, 0);
      n_add = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 30);
      for (int i = 0; i < n_add; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_cmd(3'($urandom_range(5, 7)), $urandom_range(0, 2047), $urandom_range(0, 2047),
                   rand_value(), $urandom_range(0, 4095));
        else add_random(10);
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        write_cfg(ctc_pkg::CFG_SYMMETRIC, $urandom_range(0, 1));
        if ($urandom_range(0, 2) == 0) write_cfg(ctc_pkg::CFG_ROW_COUNT, pick_dim());
      end
      send_cmd(ctc_pkg::OP_BUILD, 0, 0, '0, 0);
      if ($urandom_range(0, 3) == 0) send_cmd(ctc_pkg::OP_BUILD, 0, 0, '0, 0);
      verts = (cur_rows > cur_cols) ? cur_rows : cur_cols;
      n_read = $urandom_range(5, 40);
      for (int i = 0; i < n_read; i++) begin
        if ($urandom_range(0, 29) == 0) add_random(0);
        else read_random(verts, 2 * n_add);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/ctc_pkg.sv
rtl/ctc_ram.sv
rtl/ctc_alu.sv
rtl/coo_to_csr_converter_top.sv
verif/ctc_checker.sv
verif/tb_coo_to_csr_converter_top.sv
